// File: hdl/ppa_pkg.sv
`default_nettype none

package ppa_pkg;

    localparam int ACTION_W = 2;
    localparam int FIELD_W  = 40;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 41;
    localparam int AVAIL_W  = 42;
    localparam int LEFT_W   = 40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_ADD   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_OOM     = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_IGNORED = 3'd3,
        STAT_REGFULL = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_REF_CHECK,
        S_REF_LOAD,
        S_CARVE,
        S_HDR,
        S_POP,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [AVAIL_W-1:0] available;
        status_t            status;
        logic [FIELD_W-1:0] alloc_frame;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/physical_page_allocator.sv
// Channel | Ports             | Word contents (lowest bit first)
// input   | s_tvalid/s_tready | s_tdata: frame, page_count; s_tuser: action, usable
// result  | m_tvalid/m_tready | m_tdata: alloc_frame, available; m_tuser: status
//
// Free and add region: exec, then result; allocate without a refill: exec, pop, result.
// Allocate on an empty stack: a refill loop of carves, region reads and header releases,
// then pop and result.
// Each carve passes a check state and a push through the one free-stack write port.
// Synchronous reset clears both stack tops and the count; no clearing pass.
// One word in flight; the next is taken while the last result waits on m_tready.
`default_nettype none

module physical_page_allocator #(
    parameter int FREE_DEPTH   = 1024,
    parameter int REGION_DEPTH = 16,
    parameter int REFILL_PAGES = 4,
    parameter int FRAME_BITS   = 40
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // frame[39:0], page_count[79:40]
    input  wire logic [2:0]  s_tuser,   // action[1:0], usable[2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // alloc_frame[39:0], available[81:40], zero pad
    output logic [2:0]       m_tuser    // status[2:0]
);

    import ppa_pkg::*;

    localparam int FA_W = $clog2(FREE_DEPTH);
    localparam int RA_W = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;
    localparam int RW   = 2 * FRAME_BITS + LEFT_W;

    logic                  fr_wr_en, fr_rd_en, rg_wr_en, rg_rd_en;
    logic [FA_W-1:0]       fr_wr_addr, fr_rd_addr;
    logic [FRAME_BITS-1:0] fr_wr_data, fr_rd_data;
    logic [RA_W-1:0]       rg_wr_addr, rg_rd_addr;
    logic [RW-1:0]         rg_wr_data, rg_rd_data;
    logic                  res_valid, res_ready;
    result_t               res;
    logic                  m_valid_reg;
    result_t               m_res_reg;

    ppa_ctrl #(
        .FREE_DEPTH   (FREE_DEPTH),
        .REGION_DEPTH (REGION_DEPTH),
        .REFILL_PAGES (REFILL_PAGES),
        .FRAME_BITS   (FRAME_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser[1:0]),
        .in_frame   (s_tdata[39:0]),
        .in_pages   (s_tdata[79:40]),
        .in_usable  (s_tuser[2]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .fr_wr_en   (fr_wr_en),
        .fr_wr_addr (fr_wr_addr),
        .fr_wr_data (fr_wr_data),
        .fr_rd_en   (fr_rd_en),
        .fr_rd_addr (fr_rd_addr),
        .fr_rd_data (fr_rd_data),
        .rg_wr_en   (rg_wr_en),
        .rg_wr_addr (rg_wr_addr),
        .rg_wr_data (rg_wr_data),
        .rg_rd_en   (rg_rd_en),
        .rg_rd_addr (rg_rd_addr),
        .rg_rd_data (rg_rd_data)
    );

    ppa_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (FREE_DEPTH),
        .AW    (FA_W)
    ) u_free_ram (
        .aclk    (aclk),
        .wr_en   (fr_wr_en),
        .wr_addr (fr_wr_addr),
        .wr_data (fr_wr_data),
        .rd_en   (fr_rd_en),
        .rd_addr (fr_rd_addr),
        .rd_data (fr_rd_data)
    );

    // region entry: header, base, pages left
    ppa_ram #(
        .WIDTH (RW),
        .DEPTH (REGION_DEPTH),
        .AW    (RA_W)
    ) u_region_ram (
        .aclk    (aclk),
        .wr_en   (rg_wr_en),
        .wr_addr (rg_wr_addr),
        .wr_data (rg_wr_data),
        .rd_en   (rg_rd_en),
        .rd_addr (rg_rd_addr),
        .rd_data (rg_rd_data)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_res_reg.available, m_res_reg.alloc_frame};
    assign m_tuser  = m_res_reg.status;

endmodule

`default_nettype wire

// File: hdl/ppa_ram.sv
`default_nettype none

module ppa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/ppa_ctrl.sv
`default_nettype none

module ppa_ctrl #(
    parameter int FREE_DEPTH   = 1024,
    parameter int REGION_DEPTH = 16,
    parameter int REFILL_PAGES = 4,
    parameter int FRAME_BITS   = 40,
    parameter int FA_W = $clog2(FREE_DEPTH),
    parameter int RA_W = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1,
    parameter int RW   = 2 * FRAME_BITS + ppa_pkg::LEFT_W
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [ppa_pkg::ACTION_W-1:0]      in_action,
    input  wire logic [ppa_pkg::FIELD_W-1:0]       in_frame,
    input  wire logic [ppa_pkg::FIELD_W-1:0]       in_pages,
    input  wire logic                              in_usable,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output ppa_pkg::result_t                       res,
    output logic                                   fr_wr_en,
    output logic [FA_W-1:0]                        fr_wr_addr,
    output logic [FRAME_BITS-1:0]                  fr_wr_data,
    output logic                                   fr_rd_en,
    output logic [FA_W-1:0]                        fr_rd_addr,
    input  wire logic [FRAME_BITS-1:0]             fr_rd_data,
    output logic                                   rg_wr_en,
    output logic [RA_W-1:0]                        rg_wr_addr,
    output logic [RW-1:0]                          rg_wr_data,
    output logic                                   rg_rd_en,
    output logic [RA_W-1:0]                        rg_rd_addr,
    input  wire logic [RW-1:0]                     rg_rd_data
);

    import ppa_pkg::*;

    localparam int FT_W = $clog2(FREE_DEPTH + 1);
    localparam int RT_W = $clog2(REGION_DEPTH + 1);
    localparam int IT_W = $clog2(REFILL_PAGES + 1);
    localparam int FB   = FRAME_BITS;

    state_t              state_reg, state_next;
    action_t             act_reg;
    logic [FB-1:0]       frame_reg;
    logic [FIELD_W-1:0]  pages_reg;
    logic                usable_reg;
    logic [FT_W-1:0]     free_top_reg, free_top_next;
    logic [RT_W-1:0]     region_top_reg, region_top_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [FB-1:0]       cur_header_reg, cur_header_next;
    logic [FB-1:0]       cur_base_reg, cur_base_next;
    logic [LEFT_W-1:0]   cur_left_reg, cur_left_next;
    logic                loaded_reg, loaded_next;
    logic [IT_W-1:0]     iter_reg, iter_next;
    logic                got_sel_reg, got_sel_next;
    status_t             status_reg, status_next;

    logic                push_req, push_counted, push_do;
    logic [FB-1:0]       push_frame;
    status_t             push_stat;
    logic [COUNT_W-1:0]  cnt_inc;
    logic                cnt_dec;
    logic [AVAIL_W-1:0]  cnt_sum;
    logic [63:0]         frame_wide, carve_wide, got_wide;
    logic [LEFT_W-1:0]   left_m1;
    logic [RT_W-1:0]     rtop_m1;
    logic [FT_W-1:0]     ftop_m1;
    logic                room_two, refill_go;

    assign frame_wide = {24'd0, in_frame};
    assign left_m1    = cur_left_reg - LEFT_W'(1);
    assign carve_wide = 64'(cur_base_reg) + 64'(left_m1);
    assign rtop_m1    = region_top_reg - RT_W'(1);
    assign ftop_m1    = free_top_reg - FT_W'(1);
    assign room_two   = ({1'b0, free_top_reg} + (FT_W+1)'(2)) <= (FT_W+1)'(FREE_DEPTH);
    assign refill_go  = (iter_reg < IT_W'(REFILL_PAGES)) && (region_top_reg != '0) && room_two;

    // common push path: zero frames and a full stack are refused
    always_comb begin
        push_do   = 1'b0;
        push_stat = STAT_OK;
        if (push_frame == '0) begin
            push_stat = STAT_IGNORED;
        end else if (free_top_reg >= FT_W'(FREE_DEPTH)) begin
            push_stat = STAT_FULL;
        end else begin
            push_do = push_req;
        end
    end

    assign fr_wr_en   = push_do;
    assign fr_wr_addr = free_top_reg[FA_W-1:0];
    assign fr_wr_data = push_frame;
    assign fr_rd_addr = ftop_m1[FA_W-1:0];
    assign rg_rd_addr = rtop_m1[RA_W-1:0];

    always_comb begin
        state_next      = state_reg;
        free_top_next   = free_top_reg;
        region_top_next = region_top_reg;
        cur_header_next = cur_header_reg;
        cur_base_next   = cur_base_reg;
        cur_left_next   = cur_left_reg;
        loaded_next     = loaded_reg;
        iter_next       = iter_reg;
        got_sel_next    = got_sel_reg;
        status_next     = status_reg;
        push_req        = 1'b0;
        push_counted    = 1'b0;
        push_frame      = '0;
        cnt_inc         = '0;
        cnt_dec         = 1'b0;
        fr_rd_en        = 1'b0;
        rg_wr_en        = 1'b0;
        rg_wr_addr      = region_top_reg[RA_W-1:0];
        rg_wr_data      = {frame_reg, frame_reg + FB'(1), pages_reg - LEFT_W'(1)};
        rg_rd_en        = 1'b0;
        in_ready        = 1'b0;
        res_valid       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready     = 1'b1;
                iter_next    = '0;
                got_sel_next = 1'b0;
                loaded_next  = 1'b0;
                if (in_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RESULT;
                unique case (act_reg)
                    ACT_ALLOC: begin
                        if (free_top_reg == '0 && region_top_reg != '0) begin
                            state_next = S_REF_CHECK;
                        end else begin
                            state_next = S_POP;
                        end
                    end
                    ACT_FREE: begin
                        push_req    = 1'b1;
                        push_frame  = frame_reg;
                        status_next = push_stat;
                    end
                    ACT_ADD: begin
                        if (!usable_reg || pages_reg == '0) begin
                            status_next = STAT_IGNORED;
                        end else if (pages_reg == FIELD_W'(1)) begin
                            push_req    = 1'b1;
                            push_frame  = frame_reg;
                            status_next = push_stat;
                        end else if (region_top_reg >= RT_W'(REGION_DEPTH)) begin
                            status_next = STAT_REGFULL;
                        end else begin
                            rg_wr_en        = 1'b1;
                            region_top_next = region_top_reg + RT_W'(1);
                            cnt_inc         = {1'b0, pages_reg - LEFT_W'(1)};
                            status_next     = STAT_OK;
                        end
                    end
                    default: begin
                        status_next = STAT_IGNORED;
                    end
                endcase
                if (push_do) begin
                    free_top_next = free_top_reg + FT_W'(1);
                    cnt_inc       = COUNT_W'(1);
                end
            end
            S_REF_CHECK: begin
                if (refill_go) begin
                    if (loaded_reg) begin
                        state_next = S_CARVE;
                    end else begin
                        rg_rd_en   = 1'b1;
                        state_next = S_REF_LOAD;
                    end
                end else begin
                    if (loaded_reg) begin
                        rg_wr_en    = 1'b1;
                        rg_wr_addr  = rtop_m1[RA_W-1:0];
                        rg_wr_data  = {cur_header_reg, cur_base_reg, cur_left_reg};
                        loaded_next = 1'b0;
                    end
                    state_next = S_POP;
                end
            end
            S_REF_LOAD: begin
                {cur_header_next, cur_base_next, cur_left_next} = rg_rd_data;
                loaded_next = 1'b1;
                state_next  = S_CARVE;
            end
            S_CARVE: begin
                iter_next = iter_reg + IT_W'(1);
                if (cur_left_reg == '0) begin
                    state_next = S_HDR;
                end else begin
                    push_req      = 1'b1;
                    push_counted  = 1'b1;
                    push_frame    = carve_wide[FB-1:0];
                    cur_left_next = left_m1;
                    if (push_do) begin
                        free_top_next = free_top_reg + FT_W'(1);
                    end else begin
                        cnt_dec = 1'b1;
                    end
                    state_next = (left_m1 == '0) ? S_HDR : S_REF_CHECK;
                end
            end
            S_HDR: begin
                region_top_next = rtop_m1;
                loaded_next     = 1'b0;
                push_req        = 1'b1;
                push_frame      = cur_header_reg;
                if (push_do) begin
                    free_top_next = free_top_reg + FT_W'(1);
                    cnt_inc       = COUNT_W'(1);
                end
                state_next = S_REF_CHECK;
            end
            S_POP: begin
                if (free_top_reg == '0) begin
                    status_next  = STAT_OOM;
                    got_sel_next = 1'b0;
                end else begin
                    fr_rd_en      = 1'b1;
                    free_top_next = ftop_m1;
                    cnt_dec       = 1'b1;
                    status_next   = STAT_OK;
                    got_sel_next  = 1'b1;
                end
                state_next = S_RESULT;
            end
            S_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // saturating count update
    assign cnt_sum = {1'b0, count_reg} + {1'b0, cnt_inc};
    always_comb begin
        if (cnt_dec) begin
            count_next = (count_reg == '0) ? '0 : count_reg - COUNT_W'(1);
        end else if (cnt_sum > {1'b0, COUNT_MAX}) begin
            count_next = COUNT_MAX;
        end else begin
            count_next = cnt_sum[COUNT_W-1:0];
        end
    end

    assign got_wide        = got_sel_reg ? 64'(fr_rd_data) : 64'd0;
    assign res.alloc_frame = got_wide[FIELD_W-1:0];
    assign res.status      = status_reg;
    assign res.available   = {1'b0, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            free_top_reg   <= '0;
            region_top_reg <= '0;
            count_reg      <= '0;
            loaded_reg     <= 1'b0;
            iter_reg       <= '0;
            got_sel_reg    <= 1'b0;
            status_reg     <= STAT_OK;
        end else begin
            state_reg      <= state_next;
            free_top_reg   <= free_top_next;
            region_top_reg <= region_top_next;
            count_reg      <= count_next;
            loaded_reg     <= loaded_next;
            iter_reg       <= iter_next;
            got_sel_reg    <= got_sel_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_header_reg <= cur_header_next;
        cur_base_reg   <= cur_base_next;
        cur_left_reg   <= cur_left_next;
        if (in_valid && in_ready) begin
            act_reg    <= action_t'(in_action);
            frame_reg  <= frame_wide[FB-1:0];
            pages_reg  <= in_pages;
            usable_reg <= in_usable;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ppa_checker.sv
`default_nettype none

module ppa_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [79:0] s_tdata,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    import ppa_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one word at a time: busy the cycle after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in flight");

    // a frame is handed out only with an ok status
    a_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_OK) |-> m_tdata[39:0] == 40'd0)
        else $error("frame returned with failing status");

    // count never exceeds 41 bits
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[87:81] == 7'd0)
        else $error("available count out of range");

endmodule

bind physical_page_allocator ppa_checker u_ppa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
